// ----- sv/rkt_pkg.sv -----
`timescale 1ns / 1ps

package rkt_pkg;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [63:0]        key;
        logic signed [31:0] delta;
    } req_item_t;

    typedef struct packed {
        logic        found;
        logic [63:0] count;
        logic        removed;
        logic        full_res;
    } rsp_item_t;

    // one table entry as held in the memory
    typedef struct packed {
        logic [63:0] key;
        logic [63:0] count;
    } entry_t;

    // scan progress reported to the controller
    typedef struct packed {
        logic done;
        logic hit;
        logic free_found;
    } scan_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

// ----- sv/rkt_mem.sv -----
`timescale 1ns / 1ps

module rkt_mem #(
    parameter int ENTRIES = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
    input  rkt_pkg::entry_t                           wr_data,
    input  logic                                      rd_en,
    input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
    output rkt_pkg::entry_t                           rd_data
);

    rkt_pkg::entry_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/rkt_scan.sv -----
`timescale 1ns / 1ps

module rkt_scan #(
    parameter int ENTRIES = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [63:0]                  key,
    input  logic [ENTRIES-1:0]           valid_bits,
    output logic                         rd_en,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
    input  rkt_pkg::entry_t              rd_data,
    output rkt_pkg::scan_status_t        status,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] hit_idx,
    output logic [63:0]                  hit_count,
    output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] free_idx
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic             issue_reg, issue_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic             pend_reg, pend_next;
    logic [IDX_W-1:0] pend_idx_reg;
    logic             done_reg, done_next;
    logic             hit_reg, hit_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [63:0]      count_reg;
    logic [IDX_W-1:0] free_idx_reg;

    logic cmp_hit;
    logic cmp_free;
    logic cmp_last;

    always_comb
    begin
        cmp_hit  = pend_reg && valid_bits[pend_idx_reg] && (rd_data.key == key);
        cmp_free = pend_reg && !valid_bits[pend_idx_reg] && !free_found_reg;
        cmp_last = pend_reg && (pend_idx_reg == LAST_IDX);
    end

    always_comb
    begin
        issue_next      = issue_reg;
        addr_next       = addr_reg;
        pend_next       = issue_reg;
        done_next       = done_reg;
        hit_next        = hit_reg;
        free_found_next = free_found_reg || cmp_free;

        if (issue_reg)
        begin
            if (addr_reg == LAST_IDX)
            begin
                issue_next = 1'b0;
            end
            else
            begin
                addr_next = addr_reg + 1'b1;
            end
        end

        // stop on a match and drop the read still in flight
        if (cmp_hit)
        begin
            hit_next   = 1'b1;
            done_next  = 1'b1;
            issue_next = 1'b0;
            pend_next  = 1'b0;
        end
        else if (cmp_last)
        begin
            done_next = 1'b1;
        end

        if (start)
        begin
            issue_next      = 1'b1;
            addr_next       = '0;
            pend_next       = 1'b0;
            done_next       = 1'b0;
            hit_next        = 1'b0;
            free_found_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg      <= 1'b0;
            addr_reg       <= '0;
            pend_reg       <= 1'b0;
            done_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            issue_reg      <= issue_next;
            addr_reg       <= addr_next;
            pend_reg       <= pend_next;
            done_reg       <= done_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= addr_reg;
        if (cmp_hit)
        begin
            hit_idx_reg <= pend_idx_reg;
            count_reg   <= rd_data.count;
        end
        if (cmp_free)
        begin
            free_idx_reg <= pend_idx_reg;
        end
    end

    assign rd_en             = issue_reg;
    assign rd_addr           = addr_reg;
    assign status.done       = done_reg;
    assign status.hit        = hit_reg;
    assign status.free_found = free_found_reg;
    assign hit_idx           = hit_idx_reg;
    assign hit_count         = count_reg;
    assign free_idx          = free_idx_reg;

endmodule

// ----- sv/refcounted_key_table_core.sv -----
`timescale 1ns / 1ps

// Reference-counted key table: ENTRIES slots, each a 64-bit key with a
// 64-bit count. Requests arrive on req (op, key, delta) under
// req_valid/req_ready; each request yields one response item on rsp
// (found, count, removed, full_res) under rsp_valid/rsp_ready.
// Ops: lookup, insert (count starts at zero, lowest free slot), update
// (add the sign-extended delta; an entry whose count hits zero is freed).
// The unused op code does nothing and answers all zero.
//
// Keys and counts sit in one single-port-read memory; the controller walks
// it one entry per cycle, so the memory read port sets the rate. A match
// at slot i ends the walk there; a miss walks all ENTRIES slots. The next
// request is taken in the cycle after the response is loaded.
// Write-back happens in the cycle the response is loaded, before the next
// walk starts, so no forwarding is needed.
//
// Reset clears all slot valid bits at once (no clearing pass) and empties
// the response register. When the receiver stalls, the response holds in
// its register; the table still accepts one more request and walks it,
// then waits in its finish step until the response register frees up.

module refcounted_key_table_core #(
    parameter int ENTRIES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  rkt_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rkt_pkg::rsp_item_t rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    rkt_pkg::state_t state_reg, state_next;

    rkt_pkg::req_item_t req_hold_reg;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rkt_pkg::rsp_item_t rsp_reg;

    logic scan_start;
    logic finish_go;

    logic                  mem_rd_en;
    logic [IDX_W-1:0]      mem_rd_addr;
    rkt_pkg::entry_t       mem_rd_data;
    logic                  mem_wr_en;
    logic [IDX_W-1:0]      mem_wr_addr;
    rkt_pkg::entry_t       mem_wr_data;

    rkt_pkg::scan_status_t scan_status;
    logic [IDX_W-1:0]      hit_idx;
    logic [63:0]           hit_count;
    logic [IDX_W-1:0]      free_idx;

    rkt_pkg::rsp_item_t    result;
    logic [63:0]           upd_sum;
    logic                  ins_write;
    logic                  upd_write;
    logic                  upd_zero;

    rkt_mem #(
        .ENTRIES (ENTRIES)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    rkt_scan #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (scan_start),
        .key        (req_hold_reg.key),
        .valid_bits (valid_reg),
        .rd_en      (mem_rd_en),
        .rd_addr    (mem_rd_addr),
        .rd_data    (mem_rd_data),
        .status     (scan_status),
        .hit_idx    (hit_idx),
        .hit_count  (hit_count),
        .free_idx   (free_idx)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rkt_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = rkt_pkg::ST_SCAN;
                end
            end
            rkt_pkg::ST_SCAN:
            begin
                if (scan_status.done)
                begin
                    state_next = rkt_pkg::ST_FINISH;
                end
            end
            rkt_pkg::ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = rkt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rkt_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        req_ready  = 1'b0;
        scan_start = 1'b0;
        finish_go  = 1'b0;
        unique case (state_reg)
            rkt_pkg::ST_IDLE:
            begin
                req_ready  = 1'b1;
                scan_start = req_valid;
            end
            rkt_pkg::ST_SCAN:
            begin
            end
            rkt_pkg::ST_FINISH:
            begin
                finish_go = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
            end
        endcase
    end

    // result and write-back for the item in hand
    always_comb
    begin
        upd_sum   = hit_count + {{32{req_hold_reg.delta[31]}}, req_hold_reg.delta};
        upd_zero  = (upd_sum == 64'd0);
        ins_write = 1'b0;
        upd_write = 1'b0;
        result    = '0;

        case (req_hold_reg.op)
            rkt_pkg::OP_LOOKUP:
            begin
                if (scan_status.hit)
                begin
                    result.found = 1'b1;
                    result.count = hit_count;
                end
            end
            rkt_pkg::OP_INSERT:
            begin
                if (scan_status.hit)
                begin
                    result.found = 1'b1;
                    result.count = hit_count;
                end
                else if (scan_status.free_found)
                begin
                    ins_write = 1'b1;
                end
                else
                begin
                    result.full_res = 1'b1;
                end
            end
            rkt_pkg::OP_UPDATE:
            begin
                if (scan_status.hit)
                begin
                    upd_write      = 1'b1;
                    result.found   = 1'b1;
                    result.count   = upd_sum;
                    result.removed = upd_zero;
                end
            end
            default:
            begin
            end
        endcase

        mem_wr_en       = finish_go && (ins_write || upd_write);
        mem_wr_addr     = ins_write ? free_idx : hit_idx;
        mem_wr_data.key = req_hold_reg.key;
        mem_wr_data.count = ins_write ? 64'd0 : upd_sum;

        valid_next = valid_reg;
        if (finish_go && ins_write)
        begin
            valid_next[free_idx] = 1'b1;
        end
        if (finish_go && upd_write && upd_zero)
        begin
            valid_next[hit_idx] = 1'b0;
        end

        // hold the response until taken, load a new one on finish
        rsp_valid_next = rsp_valid_reg;
        if (finish_go)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rkt_pkg::ST_IDLE;
            valid_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_start)
        begin
            req_hold_reg <= req;
        end
        if (finish_go)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // a removed entry must have been found and must report zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!rsp.removed || (rsp.found && (rsp.count == 64'd0))))
    else $error("removed response without a found entry at zero count");

    // a full rejection reports neither a hit nor a count
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!rsp.full_res || (!rsp.found && (rsp.count == 64'd0))))
    else $error("full response carries found or count");

    // an accepted item always starts a walk
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == rkt_pkg::ST_SCAN))
    else $error("accepted item did not start a scan");

    // finishing always presents a response
    assert property (@(posedge clk) disable iff (!rst_n)
        finish_go |=> rsp_valid)
    else $error("finished item produced no response");

    // the memory is written only when an item finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (state_reg == rkt_pkg::ST_FINISH))
    else $error("table write outside the finish step");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int ENTRIES        = 16;
    localparam int POOL_SIZE      = 24;
    localparam int HOLD_CYCLES    = 400;
    // Longest quiet stretch of a correct run is the receiver hold-off plus one
    // walk of the table; take it several times over.
    localparam int WATCHDOG_LIMIT = 4000;

    // The package leaves the fourth op code unnamed; name it here.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [63:0]        KEY_LOW   = 64'h0000_0000_0000_0000;
    localparam logic [63:0]        KEY_HIGH  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0]        KEY_STRAY = 64'h0123_4567_89AB_CDEF;
    localparam logic [63:0]        KEY_MARK  = 64'hA5A5_5A5A_C3C3_3C3C;
    localparam logic signed [31:0] DELTA_MIN = 32'h8000_0000;
    localparam logic signed [31:0] DELTA_MAX = 32'h7FFF_FFFF;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               rsp_ready = 1'b0;
    rkt_pkg::req_item_t req       = '0;
    logic               req_ready;
    logic               rsp_valid;
    rkt_pkg::rsp_item_t rsp;

    // Idle and stall rates in percent, set per test.
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // Receiver hold-off: the test raises the request, the receiver counts.
    bit hold_off_req = 1'b0;
    int hold_left    = 0;

    int err_count = 0;
    int quiet_cycles = 0;
    int rsp_seen = 0;

    // Shadow of the table, advanced on every accepted request.
    bit          tbl_live  [ENTRIES];
    logic [63:0] tbl_key   [ENTRIES];
    logic [63:0] tbl_count [ENTRIES];

    rkt_pkg::rsp_item_t expected_rsp[$];
    rkt_pkg::rsp_item_t want;
    logic [63:0]        key_pool[POOL_SIZE];

    refcounted_key_table_core #(
        .ENTRIES(ENTRIES)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Table shadow
    // ------------------------------------------------------------------

    // Slot holding key k among live slots, or -1.
    function automatic int slot_of(logic [63:0] k);
        int hit;
        hit = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (tbl_live[i] && tbl_key[i] == k)
                hit = i;
        end
        return hit;
    endfunction

    function automatic int table_occupancy();
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tbl_live[i])
                n++;
        end
        return n;
    endfunction

    // Apply one request to the shadow table and return the response it owes.
    function automatic rkt_pkg::rsp_item_t table_apply(rkt_pkg::req_item_t r);
        rkt_pkg::rsp_item_t res;
        int                 hit;
        int                 spare;
        logic [63:0]        ext;
        res   = '0;
        hit   = slot_of(r.key);
        spare = -1;
        ext   = {{32{r.delta[31]}}, r.delta};
        // lowest free slot takes a new key
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!tbl_live[i])
                spare = i;
        end
        case (r.op)
            rkt_pkg::OP_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    res.found = 1'b1;
                    res.count = tbl_count[hit];
                end
            end
            rkt_pkg::OP_INSERT:
            begin
                if (hit >= 0)
                begin
                    res.found = 1'b1;
                    res.count = tbl_count[hit];
                end
                else if (spare < 0)
                    res.full_res = 1'b1;
                else
                begin
                    tbl_live[spare]  = 1'b1;
                    tbl_key[spare]   = r.key;
                    tbl_count[spare] = '0;
                end
            end
            rkt_pkg::OP_UPDATE:
            begin
                if (hit >= 0)
                begin
                    res.found      = 1'b1;
                    tbl_count[hit] = tbl_count[hit] + ext;
                    res.count      = tbl_count[hit];
                    // count hit zero: free the slot
                    if (tbl_count[hit] == '0)
                    begin
                        tbl_live[hit] = 1'b0;
                        res.removed   = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request stream and response checking
    // ------------------------------------------------------------------

    // Predict on acceptance; values read here are the pre-edge ones.
    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
            expected_rsp.push_back(table_apply(req));
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("%0t ns: mismatch on response %0d: %s", $time, rsp_seen, msg);
    endtask

    // Compare each accepted response with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
                report_mismatch($sformatf("response with nothing outstanding: %p", rsp));
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.found !== want.found)
                    report_mismatch($sformatf("found %b, want %b", rsp.found, want.found));
                if (rsp.count !== want.count)
                    report_mismatch($sformatf("count %h, want %h", rsp.count, want.count));
                if (rsp.removed !== want.removed)
                    report_mismatch($sformatf("removed %b, want %b",
                                              rsp.removed, want.removed));
                if (rsp.full_res !== want.full_res)
                    report_mismatch($sformatf("full_res %b, want %b",
                                              rsp.full_res, want.full_res));
            end
            rsp_seen++;
        end
    end

    // Receiver: stall at random, or hold off for a long stretch on request.
    always @(negedge clk)
    begin
        if (hold_off_req)
        begin
            hold_left    = HOLD_CYCLES;
            hold_off_req = 1'b0;
        end
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            rsp_ready <= 1'b0;
            hold_left--;
        end
        else
            rsp_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: count cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Offer one item, entered and left at a falling edge. Keep valid high on
    // return so that a back-to-back item does not drop it; lower it only when
    // an idle gap starts.
    task automatic send_item(input logic [1:0] op, input logic [63:0] key,
                             input logic signed [31:0] delta);
        rkt_pkg::req_item_t it;
        it.op    = op;
        it.key   = key;
        it.delta = delta;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req       <= it;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted response has come back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(negedge clk);
    endtask

    // Random request over the key pool. Updates favor deltas that walk a
    // count back to zero so that entries keep leaving and the table churns.
    function automatic rkt_pkg::req_item_t random_request();
        rkt_pkg::req_item_t r;
        int                 pick;
        int                 slot;
        logic signed [63:0] c;
        logic signed [63:0] neg;
        pick    = $urandom_range(99);
        r.key   = key_pool[$urandom_range(POOL_SIZE - 1)];
        r.delta = $urandom;
        if (pick < 28)
            r.op = rkt_pkg::OP_INSERT;
        else if (pick < 62)
            r.op = rkt_pkg::OP_UPDATE;
        else if (pick < 92)
            r.op = rkt_pkg::OP_LOOKUP;
        else
            r.op = OP_UNUSED;
        // stray keys only where they cannot take a slot
        if (r.op != rkt_pkg::OP_INSERT && $urandom_range(19) == 0)
            r.key = {$urandom, $urandom};
        if (r.op == rkt_pkg::OP_UPDATE)
        begin
            slot = slot_of(r.key);
            case ($urandom_range(9))
                0, 1, 2: r.delta = int'($urandom_range(6)) - 3;
                3, 4, 5:
                begin
                    if (slot >= 0)
                    begin
                        c = $signed(tbl_count[slot]);
                        if (c >= -64'sd2147483647 && c <= 64'sd2147483648)
                        begin
                            neg     = -c;
                            r.delta = neg[31:0];
                        end
                        else if (c > 0)
                            r.delta = DELTA_MIN;
                        else
                            r.delta = DELTA_MAX;
                    end
                end
                6: ;
                default: r.delta = $urandom_range(1000);
            endcase
        end
        return r;
    endfunction

    task automatic run_random(input int n);
        rkt_pkg::req_item_t r;
        repeat (n)
        begin
            r = random_request();
            send_item(r.op, r.key, r.delta);
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every op, extreme keys and deltas, wrap to zero, present and absent keys.
    task automatic test_basic_ops();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_item(rkt_pkg::OP_LOOKUP, KEY_LOW, 0);          // absent
        send_item(rkt_pkg::OP_INSERT, KEY_LOW, 0);
        send_item(rkt_pkg::OP_INSERT, KEY_LOW, 5);          // present: untouched
        send_item(rkt_pkg::OP_LOOKUP, KEY_LOW, 0);
        send_item(rkt_pkg::OP_UPDATE, KEY_LOW, 0);          // zero delta on zero count removes
        send_item(rkt_pkg::OP_LOOKUP, KEY_LOW, 0);
        send_item(rkt_pkg::OP_INSERT, KEY_HIGH, 0);
        send_item(rkt_pkg::OP_UPDATE, KEY_HIGH, DELTA_MIN); // sign extension
        send_item(rkt_pkg::OP_UPDATE, KEY_HIGH, DELTA_MAX);
        send_item(rkt_pkg::OP_UPDATE, KEY_HIGH, 1);         // wraps to zero, removed
        send_item(rkt_pkg::OP_UPDATE, KEY_STRAY, 5);        // update of an absent key
        send_item(rkt_pkg::OP_INSERT, KEY_MARK, 0);
        send_item(rkt_pkg::OP_UPDATE, KEY_MARK, 7);
        send_item(OP_UNUSED, KEY_MARK, -7);                 // unused op leaves the entry alone
        send_item(rkt_pkg::OP_INSERT, KEY_MARK, 0);         // present: reports count 7
        wait_drained();
    endtask

    // Fill every slot, get rejected, free one slot and reuse it.
    task automatic test_table_full();
        int n;
        n = 0;
        while (table_occupancy() < ENTRIES && n < POOL_SIZE)
        begin
            send_item(rkt_pkg::OP_INSERT, key_pool[n], 0);
            n++;
        end
        send_item(rkt_pkg::OP_INSERT, KEY_STRAY, 0);  // no free slot
        send_item(rkt_pkg::OP_LOOKUP, KEY_STRAY, 0);
        send_item(rkt_pkg::OP_UPDATE, KEY_MARK, -7);  // frees one slot
        send_item(rkt_pkg::OP_INSERT, KEY_STRAY, 0);  // takes it
        send_item(rkt_pkg::OP_UPDATE, KEY_STRAY, 0);  // and leaves again
        wait_drained();
    endtask

    task automatic test_random_steady();
        send_idle_pct = 0;
        stall_pct     = 0;
        run_random(92);
    endtask

    task automatic test_random_sender_idle();
        send_idle_pct = 85;
        stall_pct     = 0;
        run_random(92);
    endtask

    task automatic test_random_receiver_stall();
        send_idle_pct = 0;
        stall_pct     = 85;
        run_random(92);
    endtask

    task automatic test_random_both_idle();
        send_idle_pct = 18;
        stall_pct     = 18;
        run_random(92);
    endtask

    // Hold the receiver off for a long stretch while requests keep coming,
    // so the response register fills and the block stalls its input.
    task automatic test_backpressure_fill();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_off_req  = 1'b1;
        run_random(12);
    endtask

    initial
    begin
        key_pool[0] = KEY_LOW;
        key_pool[1] = KEY_HIGH;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_basic_ops();
        test_table_full();
        test_random_steady();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_backpressure_fill();

        // let a stray late response show up before judging
        repeat (ENTRIES + 8) @(posedge clk);
        if (err_count == 0 && expected_rsp.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
